// ----- rtl/hrr_pkg.sv -----
// package for the hindmarsh-rose rk4 neuron: q8.24 constants, micro-op types
// and the micro-op sequence function used by the top-level sequencer
// no dependencies
`default_nettype none

package hrr_pkg;

    localparam int QW = 32;
    localparam int FRAC = 24;
    localparam int NREG = 8;
    localparam int AW = 5;

    localparam logic signed [QW-1:0] Q_HALF = 32'sd8388608;
    localparam logic signed [QW-1:0] REST_RESET = -32'sd25165824;
    localparam logic signed [QW-1:0] RECOVERY_RESET = -32'sd171966464;
    localparam logic signed [QW-1:0] ADAPT_RESET = 32'sd1677722;
    localparam logic [QW-1:0] DIV6_MAGIC = 32'hAAAAAAAB;
    localparam int DIV6_SHIFT = 34;

    localparam logic [2:0] REG_CUBIC = 3'd0;
    localparam logic [2:0] REG_SQUARE = 3'd1;
    localparam logic [2:0] REG_ROFF = 3'd2;
    localparam logic [2:0] REG_RGAIN = 3'd3;
    localparam logic [2:0] REG_ARATE = 3'd4;
    localparam logic [2:0] REG_AGAIN = 3'd5;
    localparam logic [2:0] REG_BIAS = 3'd6;
    localparam logic [2:0] REG_STEP = 3'd7;

    localparam logic [1:0] VAR_X = 2'd0;
    localparam logic [1:0] VAR_Y = 2'd1;
    localparam logic [1:0] VAR_Z = 2'd2;
    localparam logic [2:0] STAGE_POST = 3'd4;

    typedef enum logic [1:0] {OP_MUL, OP_ADD, OP_SUB, OP_DIV6} op_t;

    typedef enum logic [3:0] {
        SRC_ZERO, SRC_V0, SRC_P, SRC_T, SRC_S2, SRC_K, SRC_SUM,
        SRC_X0, SRC_Y0, SRC_Z0, SRC_HALF, SRC_H, SRC_REST,
        SRC_CA, SRC_CB, SRC_CC
    } src_t;

    // remaining coefficients reached through a second select field
    typedef enum logic [1:0] {CX_NONE, CX_D, CX_R, CX_S} srcx_t;

    typedef enum logic [2:0] {DST_P, DST_T, DST_S2, DST_K, DST_SUM, DST_NEW} dst_t;

    typedef struct packed {
        op_t   op;
        src_t  a;
        srcx_t ax;
        src_t  b;
        srcx_t bx;
        dst_t  dst;
        logic  last;
    } uop_t;

    function automatic uop_t mk(op_t op, src_t a, src_t b, dst_t d, logic l);
        uop_t u;
        u = '{op: op, a: a, ax: CX_NONE, b: b, bx: CX_NONE, dst: d, last: l};
        return u;
    endfunction

    function automatic uop_t mkx(op_t op, srcx_t ax, src_t b, dst_t d);
        uop_t u;
        u = '{op: op, a: SRC_ZERO, ax: ax, b: b, bx: CX_NONE, dst: d, last: 1'b0};
        return u;
    endfunction

    function automatic uop_t hrr_uop(logic [1:0] vsel, logic [2:0] stage, logic [3:0] step);
        uop_t u;
        logic [3:0] np;
        logic [3:0] ns;
        logic [3:0] j;
        u = mk(OP_ADD, SRC_ZERO, SRC_ZERO, DST_T, 1'b0);
        np = (stage == 3'd0) ? 4'd1 : ((stage == 3'd3) ? 4'd2 : 4'd3);
        ns = (vsel == VAR_X) ? 4'd9 : 4'd4;
        j = step - np;
        if (stage == STAGE_POST) begin
            case (step)
                4'd0: u = mk(OP_MUL, SRC_H, SRC_SUM, DST_T, 1'b0);
                4'd1: u = mk(OP_DIV6, SRC_T, SRC_ZERO, DST_T, 1'b0);
                default: u = mk(OP_ADD, SRC_V0, SRC_T, DST_NEW, 1'b1);
            endcase
        end else if (step < np) begin
            if (stage == 3'd0) begin
                u = mk(OP_ADD, SRC_V0, SRC_ZERO, DST_P, 1'b0);
            end else if (stage == 3'd3) begin
                case (step)
                    4'd0: u = mk(OP_MUL, SRC_K, SRC_H, DST_T, 1'b0);
                    default: u = mk(OP_ADD, SRC_V0, SRC_T, DST_P, 1'b0);
                endcase
            end else begin
                case (step)
                    4'd0: u = mk(OP_MUL, SRC_HALF, SRC_K, DST_T, 1'b0);
                    4'd1: u = mk(OP_MUL, SRC_T, SRC_H, DST_T, 1'b0);
                    default: u = mk(OP_ADD, SRC_V0, SRC_T, DST_P, 1'b0);
                endcase
            end
        end else if (j >= ns) begin
            if (stage == 3'd0) begin
                u = mk(OP_ADD, SRC_K, SRC_ZERO, DST_SUM, 1'b1);
            end else begin
                u = mk(OP_ADD, SRC_SUM, SRC_K, DST_SUM, 1'b1);
            end
        end else if (vsel == VAR_X) begin
            case (j)
                4'd0: u = mk(OP_MUL, SRC_CA, SRC_P, DST_T, 1'b0);
                4'd1: u = mk(OP_MUL, SRC_T, SRC_P, DST_T, 1'b0);
                4'd2: u = mk(OP_MUL, SRC_T, SRC_P, DST_T, 1'b0);
                4'd3: u = mk(OP_MUL, SRC_CB, SRC_P, DST_S2, 1'b0);
                4'd4: u = mk(OP_MUL, SRC_S2, SRC_P, DST_S2, 1'b0);
                4'd5: u = mk(OP_SUB, SRC_Y0, SRC_T, DST_K, 1'b0);
                4'd6: u = mk(OP_ADD, SRC_K, SRC_S2, DST_K, 1'b0);
                4'd7: u = mk(OP_ADD, SRC_K, SRC_ZERO, DST_K, 1'b0);
                default: u = mk(OP_SUB, SRC_K, SRC_Z0, DST_K, 1'b0);
            endcase
            if (j == 4'd7) begin
                u.bx = CX_NONE;
                u.b = SRC_CC;
                u.op = OP_ADD;
                u.ax = CX_NONE;
                // bias current shares the cx_s select with the adaptation gain, on operand b
                u.bx = CX_S;
                u.b = SRC_ZERO;
            end
        end else if (vsel == VAR_Y) begin
            case (j)
                4'd0: u = mkx(OP_MUL, CX_D, SRC_X0, DST_T);
                4'd1: u = mk(OP_MUL, SRC_T, SRC_X0, DST_T, 1'b0);
                4'd2: u = mk(OP_SUB, SRC_CC, SRC_T, DST_K, 1'b0);
                default: u = mk(OP_SUB, SRC_K, SRC_P, DST_K, 1'b0);
            endcase
        end else begin
            case (j)
                4'd0: u = mk(OP_SUB, SRC_X0, SRC_REST, DST_T, 1'b0);
                4'd1: u = mkx(OP_MUL, CX_S, SRC_T, DST_T);
                4'd2: u = mk(OP_SUB, SRC_T, SRC_P, DST_T, 1'b0);
                default: u = mkx(OP_MUL, CX_R, SRC_T, DST_K);
            endcase
        end
        return u;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/hindmarsh_rose_rk4_neuron_top.sv -----
// hindmarsh-rose neuron advanced by fixed-point rk4, one shared multiply/add unit
// depends on hrr_pkg
`default_nettype none

// A load transaction (tuser = 1) writes x, y, z and returns x in the cycle after it is accepted.
// An advance transaction (tuser = 0) runs a micro-op sequence through a single
// 33x33 multiplier / saturating adder, one operation per cycle, for x, then y,
// then z. The result, the new x, is valid once the whole sequence is done, and
// no new transaction is taken before that result has been produced. The input
// is not ready while a sequence runs or an unclaimed result would be overwritten.
module hindmarsh_rose_rk4_neuron_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [hrr_pkg::AW-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,  // load_membrane, load_recovery, load_adapt
    input  wire logic        s_tuser,  // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata   // membrane
);
    import hrr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic signed [QW-1:0] ca_reg, cb_reg, cc_reg, cd_reg, cr_reg, cs_reg, ci_reg;
    logic [30:0] h_reg;
    logic signed [QW-1:0] x_reg, y_reg, z_reg;
    logic signed [QW-1:0] nx_reg, ny_reg, nz_reg;
    logic signed [QW-1:0] p_reg, t_reg, s2_reg, k_reg, sum_reg;
    logic [1:0] vsel_reg;
    logic [2:0] stage_reg;
    logic [3:0] step_reg;
    logic m_valid_reg, m_valid_next;
    logic [QW-1:0] m_data_reg;

    uop_t u;
    logic signed [QW-1:0] opa, opb, v0, alu_res;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic signed [41:0] shifted;
    logic signed [32:0] addsub;
    logic [31:0] absa;
    logic [31:0] quot;
    logic cfg_wr, in_acc, out_free;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_acc = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

    always_comb
    begin
        unique case (paddr[AW-1:2])
            REG_CUBIC: prdata = ca_reg;
            REG_SQUARE: prdata = cb_reg;
            REG_ROFF: prdata = cc_reg;
            REG_RGAIN: prdata = cd_reg;
            REG_ARATE: prdata = cr_reg;
            REG_AGAIN: prdata = cs_reg;
            REG_BIAS: prdata = ci_reg;
            REG_STEP: prdata = {1'b0, h_reg};
            default: prdata = '0;
        endcase
    end

    assign u = hrr_uop(vsel_reg, stage_reg, step_reg);

    always_comb
    begin
        case (vsel_reg)
            VAR_X: v0 = x_reg;
            VAR_Y: v0 = y_reg;
            default: v0 = z_reg;
        endcase
    end

    function automatic logic signed [QW-1:0] pick(src_t s, srcx_t sx,
        logic signed [QW-1:0] v0_i, logic signed [QW-1:0] p_i, logic signed [QW-1:0] t_i,
        logic signed [QW-1:0] s2_i, logic signed [QW-1:0] k_i, logic signed [QW-1:0] sum_i,
        logic signed [QW-1:0] x_i, logic signed [QW-1:0] y_i, logic signed [QW-1:0] z_i,
        logic signed [QW-1:0] h_i, logic signed [QW-1:0] a_i, logic signed [QW-1:0] b_i,
        logic signed [QW-1:0] c_i, logic signed [QW-1:0] d_i, logic signed [QW-1:0] r_i,
        logic signed [QW-1:0] sg_i, logic signed [QW-1:0] i_i, logic xs_bias);
        logic signed [QW-1:0] v;
        v = '0;
        case (sx)
            CX_D: v = d_i;
            CX_R: v = r_i;
            CX_S: v = xs_bias ? i_i : sg_i;
            default:
            begin
                case (s)
                    SRC_V0: v = v0_i;
                    SRC_P: v = p_i;
                    SRC_T: v = t_i;
                    SRC_S2: v = s2_i;
                    SRC_K: v = k_i;
                    SRC_SUM: v = sum_i;
                    SRC_X0: v = x_i;
                    SRC_Y0: v = y_i;
                    SRC_Z0: v = z_i;
                    SRC_HALF: v = Q_HALF;
                    SRC_H: v = h_i;
                    SRC_REST: v = REST_RESET;
                    SRC_CA: v = a_i;
                    SRC_CB: v = b_i;
                    SRC_CC: v = c_i;
                    default: v = '0;
                endcase
            end
        endcase
        return v;
    endfunction

    always_comb
    begin
        opa = pick(u.a, u.ax, v0, p_reg, t_reg, s2_reg, k_reg, sum_reg, x_reg, y_reg,
            z_reg, {1'b0, h_reg}, ca_reg, cb_reg, cc_reg, cd_reg, cr_reg, cs_reg, ci_reg,
            1'b0);
        opb = pick(u.b, u.bx, v0, p_reg, t_reg, s2_reg, k_reg, sum_reg, x_reg, y_reg,
            z_reg, {1'b0, h_reg}, ca_reg, cb_reg, cc_reg, cd_reg, cr_reg, cs_reg, ci_reg,
            1'b1);
    end

    always_comb
    begin
        absa = opa[QW-1] ? (32'd0 - opa) : opa;
        if (u.op == OP_DIV6) begin
            mul_a = {1'b0, absa};
            mul_b = {1'b0, DIV6_MAGIC};
        end else begin
            mul_a = {opa[QW-1], opa};
            mul_b = {opb[QW-1], opb};
        end
        prod = mul_a * mul_b;
        shifted = prod[65:FRAC];
        quot = prod[65:DIV6_SHIFT];
        addsub = (u.op == OP_SUB) ? ({opa[QW-1], opa} - {opb[QW-1], opb})
                                  : ({opa[QW-1], opa} + {opb[QW-1], opb});
        case (u.op)
            OP_MUL:
            begin
                if (shifted > 42'sh0007FFFFFFF) alu_res = 32'sh7FFFFFFF;
                else if (shifted < -42'sh00080000000) alu_res = 32'sh80000000;
                else alu_res = shifted[QW-1:0];
            end
            OP_DIV6: alu_res = opa[QW-1] ? (32'd0 - quot) : quot;
            default:
            begin
                if (addsub[32] != addsub[31])
                    alu_res = addsub[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
                else alu_res = addsub[QW-1:0];
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_acc && !s_tuser) state_next = ST_RUN;
            ST_RUN: if (u.last && stage_reg == STAGE_POST && vsel_reg == VAR_Z)
                state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        m_valid_next = m_valid_reg && !m_tready;
        if ((in_acc && s_tuser) || (state_reg == ST_DONE && out_free)) m_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
            vsel_reg <= VAR_X;
            stage_reg <= '0;
            step_reg <= '0;
            ca_reg <= 32'sd16777216;
            cb_reg <= 32'sd50331648;
            cc_reg <= 32'sd16777216;
            cd_reg <= 32'sd83886080;
            cr_reg <= 32'sd16777;
            cs_reg <= 32'sd16777216;
            ci_reg <= 32'sd16777216;
            h_reg <= 31'd167772;
            x_reg <= REST_RESET;
            y_reg <= RECOVERY_RESET;
            z_reg <= ADAPT_RESET;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr) begin
                unique case (paddr[AW-1:2])
                    REG_CUBIC: ca_reg <= pwdata;
                    REG_SQUARE: cb_reg <= pwdata;
                    REG_ROFF: cc_reg <= pwdata;
                    REG_RGAIN: cd_reg <= pwdata;
                    REG_ARATE: cr_reg <= pwdata;
                    REG_AGAIN: cs_reg <= pwdata;
                    REG_BIAS: ci_reg <= pwdata;
                    REG_STEP: h_reg <= pwdata[30:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                vsel_reg <= VAR_X;
                stage_reg <= '0;
                step_reg <= '0;
                if (s_tuser) begin
                    x_reg <= s_tdata[31:0];
                    y_reg <= s_tdata[63:32];
                    z_reg <= s_tdata[95:64];
                end
            end
            if (state_reg == ST_RUN) begin
                if (u.last) begin
                    step_reg <= '0;
                    if (stage_reg == STAGE_POST) begin
                        stage_reg <= '0;
                        vsel_reg <= vsel_reg + 2'd1;
                    end else begin
                        stage_reg <= stage_reg + 3'd1;
                    end
                end else begin
                    step_reg <= step_reg + 4'd1;
                end
            end
            if (state_reg == ST_DONE && out_free) begin
                x_reg <= nx_reg;
                y_reg <= ny_reg;
                z_reg <= nz_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RUN) begin
            case (u.dst)
                DST_P: p_reg <= alu_res;
                DST_T: t_reg <= alu_res;
                DST_S2: s2_reg <= alu_res;
                DST_K: k_reg <= alu_res;
                DST_SUM: sum_reg <= alu_res;
                default:
                begin
                    case (vsel_reg)
                        VAR_X: nx_reg <= alu_res;
                        VAR_Y: ny_reg <= alu_res;
                        default: nz_reg <= alu_res;
                    endcase
                end
            endcase
        end
        if (in_acc && s_tuser) m_data_reg <= s_tdata[31:0];
        else if (state_reg == ST_DONE && out_free) m_data_reg <= nx_reg;
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> state_reg == ST_IDLE)
        else $error("input ready outside idle");
    a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> vsel_reg <= VAR_Z && stage_reg <= STAGE_POST
            && step_reg <= 4'd12)
        else $error("sequencer out of range");
    a_adv_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !s_tuser) |=> !$rose(m_valid_reg))
        else $error("advance produced a result too early");
`endif

endmodule

`default_nettype wire
